/* rtl/cftc_pkg.sv */
`timescale 1ns / 1ps
package cftc_pkg;

  localparam int unsigned RING_DEPTH = 4096;
  localparam int unsigned PTR_W      = $clog2(RING_DEPTH);
  localparam int unsigned IN_W       = 136;
  localparam int unsigned OUT_W      = 176;

  localparam logic [31:0] PRE_DEFAULT  = 32'd10000;
  localparam logic [31:0] POST_DEFAULT = 32'd5000;
  localparam logic [3:0]  MAX_LEN      = 4'd8;
  localparam logic [11:0] CNT_MAX      = 12'd4095;

  typedef enum logic [1:0] {
    REG_ENABLED  = 2'd0,
    REG_PRE_ROLL = 2'd1,
    REG_POST_ROLL = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    KIND_RX    = 3'd0,
    KIND_TX    = 3'd1,
    KIND_ARM   = 3'd2,
    KIND_TICK  = 3'd3,
    KIND_DRAIN = 3'd4
  } kind_e;

  typedef enum logic {
    ITEM_FRAME   = 1'b0,
    ITEM_SUMMARY = 1'b1
  } item_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] now_ms;
    logic        bus;
    logic [28:0] can_id;
    logic [3:0]  dlc;
    logic [63:0] payload;
    logic [1:0]  cause;
  } cmd_t;

  typedef struct packed {
    logic [31:0] time_ms;
    logic [28:0] ident;
    logic [3:0]  len;
    logic        sent;
    logic        bus;
    logic [63:0] bytes;
  } entry_t;

  typedef struct packed {
    item_e       item_kind;
    logic [31:0] rel_ms;
    logic        frame_bus;
    logic        frame_sent;
    logic [28:0] frame_id;
    logic [3:0]  frame_len;
    logic [63:0] frame_data;
    logic [11:0] win_count;
    logic [11:0] secondary_count;
    logic [11:0] sent_count;
    logic [1:0]  trigger_cause;
    logic        last;
  } out_t;

  function automatic logic [PTR_W-1:0] step_ptr(logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [11:0] sat12(logic [PTR_W-1:0] v);
    logic [31:0] e;
    e = 32'(v);
    return (e > 32'(CNT_MAX)) ? CNT_MAX : e[11:0];
  endfunction

endpackage

/* rtl/cftc_front.sv */
`timescale 1ns / 1ps
module cftc_front import cftc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [IN_W-1:0] s_axis_tdata,
  input  logic [2:0]      s_axis_tuser,
  output logic            cmd_valid_o,
  input  logic            cmd_pop_i,
  output cmd_t            cmd_o
);

  cmd_t       fifo_q [2];
  logic       rd_q, rd_d, wr_q, wr_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       in_cmd;
  logic       push;

  always_comb begin
    in_cmd.kind    = kind_e'(s_axis_tuser);
    in_cmd.now_ms  = s_axis_tdata[31:0];
    in_cmd.bus     = s_axis_tdata[32];
    in_cmd.can_id  = s_axis_tdata[61:33];
    in_cmd.dlc     = s_axis_tdata[65:62];
    in_cmd.payload = s_axis_tdata[129:66];
    in_cmd.cause   = s_axis_tdata[131:130];
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid_o   = (cnt_q != 2'd0);
  assign cmd_o         = fifo_q[rd_q];

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = cmd_pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= in_cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* rtl/cftc_back.sv */
`timescale 1ns / 1ps
module cftc_back import cftc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_pop_o,
  input  cmd_t        cmd_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_FL_RD, ST_FL_EV, ST_FL_OUT, ST_DR_RD, ST_DR_EV
  } state_e;

  entry_t ring [RING_DEPTH];
  entry_t rd_q;

  state_e           state_q;
  logic [PTR_W-1:0] wr_ptr_q, old_ptr_q, dump_ptr_q, dump_left_q, walk_q;
  logic [PTR_W-1:0] cnt_q, sec_q, snt_q;
  logic             armed_q, started_q, enabled_q, out_valid_q;
  logic [1:0]       cause_q;
  logic [31:0]      trig_q, flush_q, first_q, wfirst_q, lo_q, pre_q, post_q;
  out_t             out_q;

  logic             out_free, in_win, rec_ok;
  logic [3:0]       len_c;
  entry_t           new_e;
  logic [31:0]      wfirst_c;
  logic [31:0]      tick_gap;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign cmd_pop_o   = (state_q == ST_IDLE) && cmd_valid_i;
  assign in_win      = (rd_q.time_ms >= lo_q) && (rd_q.time_ms <= flush_q);
  assign rec_ok      = cmd_pop_o && enabled_q && (dump_left_q == '0) &&
                       ((cmd_i.kind == KIND_RX) || (cmd_i.kind == KIND_TX));
  assign wfirst_c    = started_q ? first_q : trig_q;
  assign tick_gap    = cmd_i.now_ms - flush_q;

  always_comb begin
    len_c         = (cmd_i.dlc > MAX_LEN) ? MAX_LEN : cmd_i.dlc;
    new_e.time_ms = cmd_i.now_ms;
    new_e.ident   = cmd_i.can_id;
    new_e.len     = len_c;
    new_e.sent    = (cmd_i.kind == KIND_TX);
    new_e.bus     = cmd_i.bus;
    for (int b = 0; b < 8; b++) begin
      new_e.bytes[8*b +: 8] = (4'(b) < len_c) ? cmd_i.payload[8*b +: 8] : 8'h00;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_ok) ring[wr_ptr_q] <= new_e;
    rd_q <= ring[walk_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_ptr_q    <= '0;
      old_ptr_q   <= '0;
      dump_ptr_q  <= '0;
      dump_left_q <= '0;
      walk_q      <= '0;
      cnt_q       <= '0;
      sec_q       <= '0;
      snt_q       <= '0;
      armed_q     <= 1'b0;
      started_q   <= 1'b0;
      enabled_q   <= 1'b0;
      out_valid_q <= 1'b0;
      cause_q     <= 2'd0;
      trig_q      <= '0;
      flush_q     <= '0;
      first_q     <= '0;
      wfirst_q    <= '0;
      lo_q        <= '0;
      pre_q       <= PRE_DEFAULT;
      post_q      <= POST_DEFAULT;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_pop_o) begin
            unique case (cmd_i.kind)
              KIND_RX, KIND_TX: begin
                if (rec_ok) begin
                  if (step_ptr(wr_ptr_q) == old_ptr_q) old_ptr_q <= step_ptr(old_ptr_q);
                  wr_ptr_q <= step_ptr(wr_ptr_q);
                end
              end
              KIND_ARM: begin
                if (enabled_q && !armed_q) begin
                  armed_q <= 1'b1;
                  cause_q <= cmd_i.cause;
                  trig_q  <= cmd_i.now_ms;
                  flush_q <= cmd_i.now_ms + post_q;
                end
              end
              KIND_TICK: begin
                if (armed_q && (dump_left_q == '0) && !tick_gap[31]) begin
                  lo_q      <= (trig_q >= pre_q) ? trig_q - pre_q : 32'd0;
                  walk_q    <= old_ptr_q;
                  cnt_q     <= '0;
                  sec_q     <= '0;
                  snt_q     <= '0;
                  started_q <= 1'b0;
                  state_q   <= ST_FL_RD;
                end
              end
              KIND_DRAIN: begin
                if (dump_left_q != '0) begin
                  walk_q  <= dump_ptr_q;
                  state_q <= ST_DR_RD;
                end
              end
              default: ;
            endcase
          end
        end
        ST_FL_RD: state_q <= (walk_q == wr_ptr_q) ? ST_FL_OUT : ST_FL_EV;
        ST_FL_EV: begin
          if (rd_q.time_ms < lo_q) begin
            walk_q  <= step_ptr(walk_q);
            state_q <= ST_FL_RD;
          end else if (rd_q.time_ms > flush_q) begin
            state_q <= ST_FL_OUT;
          end else begin
            if (!started_q) begin
              started_q  <= 1'b1;
              first_q    <= rd_q.time_ms;
              dump_ptr_q <= walk_q;
            end
            cnt_q   <= cnt_q + 1'b1;
            sec_q   <= sec_q + PTR_W'(rd_q.bus);
            snt_q   <= snt_q + PTR_W'(rd_q.sent);
            walk_q  <= step_ptr(walk_q);
            state_q <= ST_FL_RD;
          end
        end
        ST_FL_OUT: begin
          if (out_free) begin
            wfirst_q              <= wfirst_c;
            dump_left_q           <= cnt_q;
            armed_q               <= 1'b0;
            out_q                 <= '0;
            out_q.item_kind       <= ITEM_SUMMARY;
            out_q.rel_ms          <= (trig_q >= wfirst_c) ? trig_q - wfirst_c : 32'd0;
            out_q.win_count       <= sat12(cnt_q);
            out_q.secondary_count <= sat12(sec_q);
            out_q.sent_count      <= sat12(snt_q);
            out_q.trigger_cause   <= cause_q;
            out_q.last            <= (cnt_q == '0);
            out_valid_q           <= 1'b1;
            state_q               <= ST_IDLE;
          end
        end
        ST_DR_RD: begin
          if (walk_q == wr_ptr_q) begin
            dump_left_q <= '0;
            state_q     <= ST_IDLE;
          end else begin
            state_q <= ST_DR_EV;
          end
        end
        ST_DR_EV: begin
          if (!in_win) begin
            walk_q  <= step_ptr(walk_q);
            state_q <= ST_DR_RD;
          end else if (out_free) begin
            out_q            <= '0;
            out_q.item_kind  <= ITEM_FRAME;
            out_q.rel_ms     <= (rd_q.time_ms >= wfirst_q) ? rd_q.time_ms - wfirst_q : 32'd0;
            out_q.frame_bus  <= rd_q.bus;
            out_q.frame_sent <= rd_q.sent;
            out_q.frame_id   <= rd_q.ident;
            out_q.frame_len  <= rd_q.len;
            out_q.frame_data <= rd_q.bytes;
            out_q.last       <= (dump_left_q == PTR_W'(1));
            out_valid_q      <= 1'b1;
            dump_left_q      <= dump_left_q - 1'b1;
            dump_ptr_q       <= step_ptr(walk_q);
            state_q          <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_ENABLED: begin
            enabled_q <= cfg_data_i[0];
            if (!cfg_data_i[0]) begin
              wr_ptr_q    <= '0;
              old_ptr_q   <= '0;
              armed_q     <= 1'b0;
              dump_left_q <= '0;
              dump_ptr_q  <= '0;
            end
          end
          REG_PRE_ROLL:  pre_q  <= cfg_data_i;
          REG_POST_ROLL: post_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

/* rtl/can_frame_trigger_capture_core.sv */
`timescale 1ns / 1ps
// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tuser kind, tdata frame/time/cause
// m_axis    out  tvalid/tready, tlast   tuser item kind, tdata result
// cfg       in   cfg_valid_i/cfg_ready_o index + 32-bit data
//
// Records and arms retire one per cycle through a two-entry command queue,
// except while a tick or drain walks the ring. Both walks go slot by slot;
// each slot passes through a read state and then an evaluate state, set by
// the single registered ring read port.
// Results sit in an output register; the walk stalls at a result to emit while that register holds an untaken one.
// Reset empties the ring pointers; ring contents need no clearing.
module can_frame_trigger_capture_core import cftc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,  // now_ms, bus, can_id, dlc, payload, cause
  input  logic [2:0]       s_axis_tuser,  // kind
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,  // rel_ms, frame_bus, frame_sent, frame_id,
                                          // frame_len, frame_data, win_count,
                                          // secondary_count, sent_count, trigger_cause
  output logic             m_axis_tuser,  // item_kind
  output logic             m_axis_tlast,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i
);

  logic cmd_valid, cmd_pop;
  cmd_t cmd;
  out_t res;

  assign cfg_ready_o = 1'b1;

  cftc_front u_front (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop), .cmd_o(cmd)
  );

  cftc_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop), .cmd_i(cmd),
    .cfg_we_i(cfg_valid_i), .cfg_index_i, .cfg_data_i,
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_o(res)
  );

  assign m_axis_tuser = res.item_kind;
  assign m_axis_tlast = res.last;
  assign m_axis_tdata = {7'd0, res.trigger_cause, res.sent_count, res.secondary_count,
                         res.win_count, res.frame_data, res.frame_len, res.frame_id,
                         res.frame_sent, res.frame_bus, res.rel_ms};

endmodule

/* rtl/cftc_checker.sv */
`timescale 1ns / 1ps
module cftc_checker import cftc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic             m_axis_tuser,
  input logic             m_axis_tlast
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("valid dropped");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("data moved");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser && (m_axis_tdata[142:131] == 12'd0) |-> m_axis_tlast)
    else $error("empty summary not last");

  a_frame_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[168:131] == '0))
    else $error("frame item carries counts");

  a_summary_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[130:32] == '0))
    else $error("summary carries frame fields");

endmodule

bind can_frame_trigger_capture_core cftc_checker u_cftc_checker (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
  .m_axis_tlast
);
